@@ rtl/core/schd_pkg.sv @@
`timescale 1ns / 1ps

package schd_pkg;

    // Result status codes
    typedef enum logic [1:0] {
        ST_PAYLOAD  = 2'd0,
        ST_SHORT    = 2'd1,
        ST_BADMAGIC = 2'd2,
        ST_EMPTY    = 2'd3
    } t_status;

    // Register map, word index (byte address = 4 * index)
    typedef enum logic [1:0] {
        REG_SEED  = 2'd0,
        REG_MULT  = 2'd1,
        REG_INCR  = 2'd2,
        REG_MAGIC = 2'd3
    } t_reg_idx;

    localparam logic [15:0] SEED_RST  = 16'd1124;
    localparam logic [15:0] MULT_RST  = 16'd52845;
    localparam logic [15:0] INCR_RST  = 16'd22719;
    localparam logic [31:0] MAGIC_RST = 32'h4B53_4301; // "KSC" then 1

    localparam logic [3:0] POS_MAGIC   = 4'd4;  // first header byte checked
    localparam logic [3:0] POS_LASTHDR = 4'd7;
    localparam logic [3:0] POS_PAYLOAD = 4'd8;  // saturates here

    typedef struct packed {
        logic [15:0] seed;
        logic [15:0] mult;
        logic [15:0] incr;
        logic [31:0] magic;
    } t_cfg;

    typedef struct packed {
        logic [15:0] key;
        logic [3:0]  pos;
        logic        magic_ok;
        logic        rejected;
    } t_state;

    typedef struct packed {
        logic [7:0] plain;
        t_status    status;
        logic       eof;
    } t_result;

endpackage

@@ rtl/core/stream_cipher_header_decryptor_unit.sv @@
`timescale 1ns / 1ps

// Header-checking stream decryptor.
// Input stream (s_*): one cipher byte per transaction in s_tdata, s_tlast
//   marks the final byte of a file. Output stream (m_*): m_tdata carries the
//   plain byte, m_tuser the status (payload, file too short, bad magic, empty
//   payload), m_tlast the end of the file's results.
// Bytes 0..3 only advance the key, bytes 4..7 are checked against the magic
//   word, later bytes are decrypted and sent as payload. After a bad magic
//   word the rest of the file is dropped silently.
// Throughput: one byte per cycle while s_tready is high. The whole step (16x16 key multiply-add,
//   XOR, header compare) sits between the state registers and the result
//   register, and the key recurrence closes within that combinational step.
// Each result is registered, into the output register or, while that is full and not draining, into the skid entry.
// Stall: results sit in an output register backed by one skid entry; input
//   keeps flowing until both are full, then s_tready drops.
// Reset (synchronous, active low) restores register defaults and starts a
//   new file; the APB port writes registers, intended only while idle.
module stream_cipher_header_decryptor_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // APB register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] cipher_byte
    input  logic        s_tlast,   // last_byte
    // output stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] plain_byte
    output logic [1:0]  m_tuser,   // [1:0] status
    output logic        m_tlast    // end_of_file
);
    import schd_pkg::*;

    t_cfg     r_cfg;
    t_state   r_state;
    t_state   n_state;
    logic     w_push;
    t_result  w_result;

    t_result  r_out;
    logic     r_out_valid;
    t_result  r_skid;
    logic     r_skid_valid;

    logic     w_accept;
    logic     w_pop;
    logic     w_cfg_wr;
    t_reg_idx w_idx;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;
    assign w_idx    = t_reg_idx'(paddr[3:2]);

    // ---- configuration registers ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.seed  <= SEED_RST;
            r_cfg.mult  <= MULT_RST;
            r_cfg.incr  <= INCR_RST;
            r_cfg.magic <= MAGIC_RST;
        end else if (w_cfg_wr) begin
            unique case (w_idx)
                REG_SEED:  r_cfg.seed  <= pwdata[15:0];
                REG_MULT:  r_cfg.mult  <= pwdata[15:0];
                REG_INCR:  r_cfg.incr  <= pwdata[15:0];
                REG_MAGIC: r_cfg.magic <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_SEED:  prdata = {16'd0, r_cfg.seed};
            REG_MULT:  prdata = {16'd0, r_cfg.mult};
            REG_INCR:  prdata = {16'd0, r_cfg.incr};
            REG_MAGIC: prdata = r_cfg.magic;
            default:   prdata = '0;
        endcase
    end

    // ---- decrypt step ----
    schd_step u_step (
        .i_cfg    (r_cfg),
        .i_state  (r_state),
        .i_byte   (s_tdata),
        .i_last   (s_tlast),
        .o_state  (n_state),
        .o_push   (w_push),
        .o_result (w_result)
    );

    assign s_tready = !r_skid_valid;
    assign w_accept = s_tvalid && s_tready;
    assign w_pop    = r_out_valid && m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.key      <= SEED_RST;
            r_state.pos      <= '0;
            r_state.magic_ok <= 1'b1;
            r_state.rejected <= 1'b0;
        end else if (w_accept) begin
            r_state <= n_state;
        end
    end

    // ---- output register plus skid entry ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            // input is held off; drain skid into the output register
            if (w_pop) begin
                r_skid_valid <= 1'b0;
            end
        end else if (w_pop || !r_out_valid) begin
            r_out_valid <= w_accept && w_push;
        end else if (w_accept && w_push) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (w_pop) begin
                r_out <= r_skid;
            end
        end else if (w_pop || !r_out_valid) begin
            r_out <= w_result;
        end else begin
            r_skid <= w_result;
        end
    end

    assign m_tvalid = r_out_valid;
    assign m_tdata  = r_out.plain;
    assign m_tuser  = r_out.status;
    assign m_tlast  = r_out.eof;

    // ---- assertions ----
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry held with empty output register");

    a_skid_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid && m_tready |=> m_tvalid && !r_skid_valid)
        else $error("skid entry lost on drain");

    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.pos <= POS_PAYLOAD)
        else $error("byte position out of range");

    a_last_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_tvalid && s_tready && s_tlast |=> r_state.pos == '0 && !r_state.rejected)
        else $error("file state not restarted after last byte");

    a_reject_consistent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.rejected |-> r_state.pos == POS_PAYLOAD && !r_state.magic_ok)
        else $error("rejected file without failed magic");

endmodule

@@ rtl/core/schd_step.sv @@
`timescale 1ns / 1ps

// One decrypt step: next file state and the optional result for one byte.
module schd_step (
    input  schd_pkg::t_cfg    i_cfg,
    input  schd_pkg::t_state  i_state,
    input  logic [7:0]        i_byte,
    input  logic              i_last,
    output schd_pkg::t_state  o_state,
    output logic              o_push,
    output schd_pkg::t_result o_result
);
    import schd_pkg::*;

    logic [15:0] w_key;
    logic [7:0]  w_plain;
    logic [15:0] w_sum;
    logic [31:0] w_prod;
    logic [15:0] w_key_next;
    logic [7:0]  w_want;
    logic        w_magic_ok;
    t_state      w_restart;

    assign w_key      = (i_state.pos == '0) ? i_cfg.seed : i_state.key;
    assign w_plain    = i_byte ^ w_key[15:8];
    assign w_sum      = {8'd0, i_byte} + w_key;
    assign w_prod     = w_sum * i_cfg.mult;
    assign w_key_next = w_prod[15:0] + i_cfg.incr;

    // header byte 4 compares against the top byte of the magic word
    always_comb begin
        unique case (i_state.pos[1:0])
            2'd0: w_want = i_cfg.magic[31:24];
            2'd1: w_want = i_cfg.magic[23:16];
            2'd2: w_want = i_cfg.magic[15:8];
            2'd3: w_want = i_cfg.magic[7:0];
            default: w_want = i_cfg.magic[7:0];
        endcase
    end

    assign w_magic_ok = i_state.magic_ok && (w_plain == w_want);

    always_comb begin
        w_restart.key      = i_cfg.seed;
        w_restart.pos      = '0;
        w_restart.magic_ok = 1'b1;
        w_restart.rejected = 1'b0;
    end

    always_comb begin
        o_state          = i_state;
        o_state.key      = w_key_next;
        o_push           = 1'b0;
        o_result.plain   = '0;
        o_result.status  = ST_PAYLOAD;
        o_result.eof     = 1'b1;

        priority if (i_state.pos < POS_MAGIC) begin
            o_state.pos = i_state.pos + 4'd1;
            if (i_last) begin
                o_push          = 1'b1;
                o_result.status = ST_SHORT;
                o_state         = w_restart;
            end
        end else if (i_state.pos < POS_PAYLOAD) begin
            o_state.pos      = i_state.pos + 4'd1;
            o_state.magic_ok = w_magic_ok;
            if (i_state.pos == POS_LASTHDR) begin
                if (!w_magic_ok) begin
                    o_push          = 1'b1;
                    o_result.status = ST_BADMAGIC;
                    if (i_last) begin
                        o_state = w_restart;
                    end else begin
                        o_state.rejected = 1'b1;
                    end
                end else if (i_last) begin
                    o_push          = 1'b1;
                    o_result.status = ST_EMPTY;
                    o_state         = w_restart;
                end
            end else if (i_last) begin
                o_push          = 1'b1;
                o_result.status = ST_SHORT;
                o_state         = w_restart;
            end
        end else begin
            o_state.pos = POS_PAYLOAD;
            if (!i_state.rejected) begin
                o_push          = 1'b1;
                o_result.plain  = w_plain;
                o_result.status = ST_PAYLOAD;
                o_result.eof    = i_last;
            end
            if (i_last) begin
                o_state = w_restart;
            end
        end
    end

endmodule
